FILE: sv/nasimsi_pkg.sv
// Package for the NAS identity IMSI extractor core.
// Holds the identity mode type, protocol constants and stream widths; no dependencies.
`default_nettype none

package nasimsi_pkg;

  // Identity layout chosen by the first identity byte.
  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_PLAIN  = 2'd1,
    MODE_SUCI   = 2'd2,
    MODE_REJECT = 2'd3
  } mode_t;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned DIGITS_W    = 60;
  localparam int unsigned NUM_DIGITS  = 15;

  localparam logic [7:0] MSG_TYPE_ID_RESP = 8'h5C;
  localparam logic [3:0] EPD_5GMM_NIBBLE  = 4'h7;
  localparam logic [3:0] NIBBLE_FILLER    = 4'hF;
  localparam logic [3:0] NIBBLE_MAX_DIGIT = 4'h9;
  localparam logic [3:0] NIBBLE_ZERO      = 4'h0;
  localparam logic [7:0] SUCI_FIRST_BYTE  = 8'h01;
  localparam logic [2:0] IMSI_TYPE_CODE   = 3'b001;

  localparam logic [7:0] SUCI_MIN_SELECT_LEN = 8'd8;
  localparam logic [7:0] SUCI_MIN_FOUND_LEN  = 8'd9;
  localparam logic [7:0] MIN_IDENTITY_LEN    = 8'd2;
  localparam logic [4:0] MIN_DIGITS          = 5'd5;
  localparam logic [4:0] MAX_DIGITS          = 5'd15;
  localparam logic [4:0] DIGITS_OVERFLOW     = 5'd16;

  // Identity byte offsets inside a SUCI.
  localparam logic [8:0] SUCI_IDX_MCC12   = 9'd1;
  localparam logic [8:0] SUCI_IDX_MCC3    = 9'd2;
  localparam logic [8:0] SUCI_IDX_MNC     = 9'd3;
  localparam logic [8:0] SUCI_IDX_SCHEME  = 9'd6;
  localparam logic [8:0] SUCI_IDX_MSIN    = 9'd8;

  localparam logic [8:0] POS_MAX = 9'd511;

endpackage

`default_nettype wire

FILE: sv/nas_identity_imsi_extractor_core.sv
// NAS identity IMSI extractor: parses one NAS Identity Response per frame of byte beats.
// Depends on nasimsi_pkg for the mode type and protocol constants.
// The parse state updates once per byte, and a last beat loads the result register.
// One byte beat per cycle; a last beat waits while a held result is not taken.
// The input register holds one beat; the result register holds one result beat.
// Reset (rst_n low, synchronous) empties both registers and clears the parse state.
`default_nettype none

module nas_identity_imsi_extractor_core
  import nasimsi_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input channel. tdata bits 7:0 = data_byte. tlast = last_byte.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   in_tlast,
  // Result channel. tdata from bit 0 up: identity_found (1), identity_kind (1),
  // digit_count (4), imsi_digits (60), zero padding (6).
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  // Input register stage.
  logic                  s1_valid_r;
  logic [7:0]            s1_byte_r;
  logic                  s1_last_r;
  logic                  s1_go;

  // Parse state for the message in flight.
  logic [8:0]            pos_r;
  logic                  fh_r;
  logic                  tm_r;
  logic [7:0]            len_r;
  mode_t                 mode_r;
  logic                  perr_r;
  logic [3:0]            pend_r;
  logic [DIGITS_W-1:0]   store_r;
  logic [4:0]            held_r;
  logic                  filler_r;
  logic                  nz_r;

  logic                  fh_nxt;
  logic                  tm_nxt;
  logic [7:0]            len_nxt;
  mode_t                 mode_nxt;
  logic                  perr_nxt;
  logic [3:0]            pend_nxt;
  logic [DIGITS_W-1:0]   store_nxt;
  logic [4:0]            held_nxt;
  logic                  filler_nxt;
  logic                  nz_nxt;
  logic                  found;

  // Result register.
  logic                  out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_data_nxt;

  // The stored beat moves on unless it is a last beat and the result
  // register is still full and not being taken.
  assign s1_go     = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // Per-byte parse update. Up to three digits can be produced from one byte
  // (the SUCI MNC byte also flushes the held third MNC digit); they are
  // packed into the digit store at consecutive positions.
  always_comb begin
    logic [3:0]  lo;
    logic [3:0]  hi;
    logic [8:0]  idstart;
    logic [8:0]  idx;
    logic        in_id;
    logic        f1;
    logic [3:0]  cd [3];
    logic        cv [3];
    logic [4:0]  h;
    logic [9:0]  pos_inc;
    logic [9:0]  id_end;

    lo = s1_byte_r[3:0];
    hi = s1_byte_r[7:4];
    fh_nxt     = fh_r;
    tm_nxt     = tm_r;
    len_nxt    = len_r;
    mode_nxt   = mode_r;
    perr_nxt   = perr_r;
    pend_nxt   = pend_r;
    filler_nxt = filler_r;
    nz_nxt     = nz_r;
    f1         = filler_r;
    for (int k = 0; k < 3; k++) begin
      cd[k] = NIBBLE_ZERO;
      cv[k] = 1'b0;
    end

    // Header: a full 5GMM header carries the message type in byte 1.
    if (pos_r == '0) begin
      fh_nxt = (lo == EPD_5GMM_NIBBLE);
      if (!fh_nxt) begin
        tm_nxt = (s1_byte_r == MSG_TYPE_ID_RESP);
      end
    end else if (pos_r == 9'd1 && fh_r) begin
      tm_nxt = (s1_byte_r == MSG_TYPE_ID_RESP);
    end

    idstart = fh_nxt ? 9'd4 : 9'd3;
    if (pos_r == idstart - 9'd1) begin
      len_nxt = s1_byte_r;
    end
    idx   = pos_r - idstart;
    in_id = (pos_r >= idstart) && (idx < {1'b0, len_r});

    if (in_id) begin
      if (idx == '0) begin
        if (s1_byte_r == SUCI_FIRST_BYTE && len_r >= SUCI_MIN_SELECT_LEN) begin
          mode_nxt = MODE_SUCI;
        end else if (s1_byte_r[2:0] == IMSI_TYPE_CODE) begin
          mode_nxt = MODE_PLAIN;
          cd[0] = hi;
          cv[0] = (hi <= NIBBLE_MAX_DIGIT);
        end else begin
          mode_nxt = MODE_REJECT;
        end
      end else if (mode_r == MODE_PLAIN || (mode_r == MODE_SUCI && idx >= SUCI_IDX_MSIN)) begin
        // TBCD pair, low nibble first; a filler nibble ends all decoding.
        cd[0] = lo;
        cv[0] = !filler_r && (lo <= NIBBLE_MAX_DIGIT);
        f1    = filler_r || (lo == NIBBLE_FILLER);
        cd[1] = hi;
        cv[1] = !f1 && (hi <= NIBBLE_MAX_DIGIT);
        filler_nxt = f1 || (hi == NIBBLE_FILLER);
      end else if (mode_r == MODE_SUCI) begin
        case (idx)
          SUCI_IDX_MCC12: begin
            cd[0] = lo;
            cv[0] = (lo <= NIBBLE_MAX_DIGIT);
            cd[1] = hi;
            cv[1] = (hi <= NIBBLE_MAX_DIGIT);
            if (lo > NIBBLE_MAX_DIGIT || hi > NIBBLE_MAX_DIGIT) begin
              perr_nxt = 1'b1;
            end
          end
          SUCI_IDX_MCC3: begin
            cd[0] = lo;
            cv[0] = (lo <= NIBBLE_MAX_DIGIT);
            if (lo > NIBBLE_MAX_DIGIT) begin
              perr_nxt = 1'b1;
            end
            pend_nxt = hi;
          end
          SUCI_IDX_MNC: begin
            cd[0] = lo;
            cv[0] = (lo <= NIBBLE_MAX_DIGIT);
            cd[1] = hi;
            cv[1] = (hi <= NIBBLE_MAX_DIGIT);
            cd[2] = pend_r;
            cv[2] = (pend_r <= NIBBLE_MAX_DIGIT);
            if (lo > NIBBLE_MAX_DIGIT || hi > NIBBLE_MAX_DIGIT ||
                (pend_r != NIBBLE_FILLER && pend_r > NIBBLE_MAX_DIGIT)) begin
              perr_nxt = 1'b1;
            end
          end
          SUCI_IDX_SCHEME: begin
            if (lo != NIBBLE_ZERO) begin
              perr_nxt = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end

    // Pack the produced digits. Digits past the fifteenth only count, and the
    // count sticks at sixteen to mark an overlong identity.
    h = held_r;
    store_nxt = store_r;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < NUM_DIGITS; j++) begin
        if (cv[k] && h == 5'(j)) begin
          store_nxt[j*4 +: 4] = cd[k];
        end
      end
      if (cv[k] && h < DIGITS_OVERFLOW) begin
        h = h + 5'd1;
      end
      if (cv[k] && cd[k] != NIBBLE_ZERO) begin
        nz_nxt = 1'b1;
      end
    end
    held_nxt = h;

    // Verdict on the state as it stands after this byte.
    pos_inc = {1'b0, pos_r} + 10'd1;
    id_end  = {1'b0, idstart} + {2'b00, len_nxt};
    found = tm_nxt
         && (pos_inc >= {1'b0, idstart})
         && (len_nxt >= MIN_IDENTITY_LEN)
         && (pos_inc >= id_end)
         && (mode_nxt == MODE_PLAIN || mode_nxt == MODE_SUCI)
         && !perr_nxt
         && (mode_nxt != MODE_SUCI || len_nxt >= SUCI_MIN_FOUND_LEN)
         && (held_nxt >= MIN_DIGITS) && (held_nxt <= MAX_DIGITS)
         && nz_nxt;

    out_data_nxt = '0;
    if (found) begin
      out_data_nxt[0]    = 1'b1;
      out_data_nxt[1]    = (mode_nxt == MODE_SUCI);
      out_data_nxt[5:2]  = held_nxt[3:0];
      out_data_nxt[65:6] = store_nxt;
    end
  end

  // Parse state: advances on each byte and returns to its reset value after
  // the last byte of a message.
  always_ff @(posedge clk) begin
    if (!rst_n || (s1_go && s1_last_r)) begin
      pos_r    <= '0;
      fh_r     <= 1'b0;
      tm_r     <= 1'b0;
      len_r    <= '0;
      mode_r   <= MODE_NONE;
      perr_r   <= 1'b0;
      pend_r   <= NIBBLE_FILLER;
      store_r  <= '0;
      held_r   <= '0;
      filler_r <= 1'b0;
      nz_r     <= 1'b0;
    end else if (s1_go) begin
      pos_r    <= (pos_r == POS_MAX) ? pos_r : pos_r + 9'd1;
      fh_r     <= fh_nxt;
      tm_r     <= tm_nxt;
      len_r    <= len_nxt;
      mode_r   <= mode_nxt;
      perr_r   <= perr_nxt;
      pend_r   <= pend_nxt;
      store_r  <= store_nxt;
      held_r   <= held_nxt;
      filler_r <= filler_nxt;
      nz_r     <= nz_nxt;
    end
  end

  // Result register: loaded by a last beat, emptied when the result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A found identity always carries between five and fifteen digits.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[0] |-> out_data_r[5:2] >= 4'd5)
    else $error("found identity with too few digits");

  // A result without an identity carries all-zero fields.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r[0] |-> out_data_r[OUT_TDATA_W-1:1] == '0)
    else $error("result fields not cleared when no identity found");

  // Ending a message returns the parser to the start of the next one.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_last_r |=> pos_r == '0 && held_r == '0 && mode_r == MODE_NONE)
    else $error("parse state not cleared after last beat");

  // The digit count never passes its overflow mark.
  assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= DIGITS_OVERFLOW)
    else $error("digit count beyond overflow mark");

endmodule

`default_nettype wire
